// ----- rtl/bclp_pkg.sv -----
// ============================================================================
// bclp_pkg
// Shared types and constants for the button click / long-press detector.
// ============================================================================
package bclp_pkg;

    // Default width of the internal millisecond timebase
    localparam int TIME_BITS_DEF = 32;

    // Field widths fixed by the stream format
    localparam int NOW_BITS    = 32;
    localparam int CLICK_BITS  = 8;
    localparam int CFG_BITS    = 16;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CLICK_BITS-1:0] CLICK_MAX = '1;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_ACTIVE_LOW = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD_TIME  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CLICK_GAP  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEBOUNCE   = 2'd3;

    // Reset values of the configuration registers
    localparam logic                RST_ACTIVE_LOW = 1'b1;
    localparam logic [CFG_BITS-1:0] RST_HOLD_TIME  = 16'd1000;
    localparam logic [CFG_BITS-1:0] RST_CLICK_GAP  = 16'd400;
    localparam logic [CFG_BITS-1:0] RST_DEBOUNCE   = 16'd50;

    // Reported event codes
    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_CLICK  = 3'd1,
        EV_LSTART = 3'd2,
        EV_LREP   = 3'd3,
        EV_LEND   = 3'd4
    } t_event;

    // Configuration set handed to the submodules
    typedef struct packed {
        logic                active_low;
        logic [CFG_BITS-1:0] hold_time;
        logic [CFG_BITS-1:0] click_gap;
        logic [CFG_BITS-1:0] debounce;
    } t_cfg;

endpackage

// ----- rtl/bclp_debounce.sv -----
// ============================================================================
// bclp_debounce
// Pin sense correction and debounce filter; one sample per enabled cycle.
// ============================================================================
module bclp_debounce #(
    parameter int TIME_BITS = bclp_pkg::TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_raw_level,
    input  logic [TIME_BITS-1:0] i_now,
    input  bclp_pkg::t_cfg       i_cfg,
    output logic                 o_stable_next,
    output logic                 o_stable
);

    logic                 r_prev;
    logic                 r_stable;
    logic [TIME_BITS-1:0] r_change_time;
    logic                 n_prev;
    logic                 n_stable;
    logic [TIME_BITS-1:0] n_change_time;
    logic [TIME_BITS-1:0] w_elapsed;

    always_comb begin
        n_prev        = i_raw_level ^ i_cfg.active_low;
        n_change_time = (n_prev != r_prev) ? i_now : r_change_time;
        w_elapsed     = i_now - n_change_time;
        n_stable      = (w_elapsed > TIME_BITS'(i_cfg.debounce)) ? n_prev : r_stable;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev        <= 1'b0;
            r_stable      <= 1'b0;
            r_change_time <= '0;
        end else if (i_en) begin
            r_prev        <= n_prev;
            r_stable      <= n_stable;
            r_change_time <= n_change_time;
        end
    end

    assign o_stable_next = n_stable;
    assign o_stable      = r_stable;

endmodule

// ----- rtl/bclp_phase_fsm.sv -----
// ============================================================================
// bclp_phase_fsm
// Click / long-press phase machine driven by the debounced level.
// ============================================================================
module bclp_phase_fsm #(
    parameter int TIME_BITS = bclp_pkg::TIME_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_act,
    input  logic [TIME_BITS-1:0]            i_now,
    input  bclp_pkg::t_cfg                  i_cfg,
    output bclp_pkg::t_event                o_event,
    output logic [bclp_pkg::CLICK_BITS-1:0] o_clicks
);

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_PRESSED    = 4'd1,
        PH_RELEASED   = 4'd2,
        PH_COUNTING   = 4'd3,
        PH_CLICK1     = 4'd4,
        PH_CLICK2     = 4'd5,
        PH_CLICKN     = 4'd6,
        PH_LONG_START = 4'd7,
        PH_LONG       = 4'd8,
        PH_LONG_END   = 4'd9
    } t_phase;

    t_phase                          r_phase, n_phase;
    logic [bclp_pkg::CLICK_BITS-1:0] r_count, n_count;
    logic [TIME_BITS-1:0]            r_press_t, n_press_t;
    logic [TIME_BITS-1:0]            r_release_t, n_release_t;
    logic [TIME_BITS-1:0]            r_repeat_t, n_repeat_t;
    bclp_pkg::t_event                n_event;

    logic [TIME_BITS-1:0] w_since_press;
    logic [TIME_BITS-1:0] w_since_release;
    logic [TIME_BITS-1:0] w_since_repeat;
    logic [TIME_BITS-1:0] w_hold;
    t_phase               w_click_phase;

    always_comb begin
        w_since_press   = i_now - r_press_t;
        w_since_release = i_now - r_release_t;
        w_since_repeat  = i_now - r_repeat_t;
        w_hold          = TIME_BITS'(i_cfg.hold_time);
        if (r_count == bclp_pkg::CLICK_BITS'(1)) begin
            w_click_phase = PH_CLICK1;
        end else if (r_count == bclp_pkg::CLICK_BITS'(2)) begin
            w_click_phase = PH_CLICK2;
        end else begin
            w_click_phase = PH_CLICKN;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_count     = r_count;
        n_press_t   = r_press_t;
        n_release_t = r_release_t;
        n_repeat_t  = r_repeat_t;
        n_event     = bclp_pkg::EV_NONE;
        unique case (r_phase)
            PH_PRESSED: begin
                if (!i_act) begin
                    n_release_t = i_now;
                    if (r_count != bclp_pkg::CLICK_MAX) begin
                        n_count = r_count + bclp_pkg::CLICK_BITS'(1);
                    end
                    n_phase = PH_RELEASED;
                end else if (w_since_press > w_hold) begin
                    // earlier clicks turn a long hold into a click report
                    n_phase = (r_count == '0) ? PH_LONG_START : w_click_phase;
                end
            end
            PH_LONG_START: begin
                n_repeat_t = i_now;
                n_event    = bclp_pkg::EV_LSTART;
                n_phase    = PH_LONG;
            end
            PH_LONG: begin
                if (!i_act) begin
                    n_release_t = i_now;
                    n_phase     = PH_LONG_END;
                end else if (w_since_repeat > w_hold) begin
                    n_repeat_t = i_now;
                    n_event    = bclp_pkg::EV_LREP;
                end
            end
            PH_LONG_END: begin
                n_event = bclp_pkg::EV_LEND;
                n_phase = PH_RELEASED;
            end
            PH_RELEASED: begin
                if (w_since_release > TIME_BITS'(i_cfg.debounce)) begin
                    n_phase = PH_COUNTING;
                end
            end
            PH_COUNTING: begin
                if (i_act) begin
                    n_press_t = i_now;
                    n_phase   = PH_PRESSED;
                end else if (w_since_release >= TIME_BITS'(i_cfg.click_gap)) begin
                    if (r_count != '0) begin
                        n_phase = w_click_phase;
                    end
                end
            end
            PH_CLICK1, PH_CLICK2, PH_CLICKN: begin
                n_event = bclp_pkg::EV_CLICK;
                n_phase = PH_IDLE;
            end
            default: begin
                // idle, and any stray code behaves as idle
                if (i_act) begin
                    n_press_t = i_now;
                    n_count   = '0;
                    n_phase   = PH_PRESSED;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_count     <= '0;
            r_press_t   <= '0;
            r_release_t <= '0;
            r_repeat_t  <= '0;
        end else if (i_en) begin
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_press_t   <= n_press_t;
            r_release_t <= n_release_t;
            r_repeat_t  <= n_repeat_t;
        end
    end

    // A click report carries the pre-step count, which the click phases leave unchanged
    assign o_event  = n_event;
    assign o_clicks = n_count;

endmodule

// ----- rtl/button_click_long_press_detector.sv -----
// ============================================================================
// button_click_long_press_detector
// Debounces sampled button levels and reports clicks and long presses.
// ============================================================================
//
//  channel   dir  handshake                      payload (low bit up)
//  -------   ---  -----------------------------  ---------------------------------
//  s_axis    in   s_axis_tvalid / s_axis_tready  raw_level[0], now_ms[32:1]
//  m_axis    out  m_axis_tvalid / m_axis_tready  event_res[2:0], clicks[10:3],
//                                                pressed[11]
//  cfg       in   i_cfg_we (no wait)             i_cfg_idx, i_cfg_wdata
//
//  One sample per cycle sustained while the sink keeps m_axis_tready high; each
//  sample yields exactly one result word. A sample passes the input register, then
//  the result register; the debounce filter and phase machine sit between them as
//  one short compare path. A stalled result register holds the input stage;
//  s_axis_tready stays high while the input register is empty or can move on.
//  i_rst_n is synchronous, active low: phase idle, counts and times zero,
//  configuration back to its defaults.
//
module button_click_long_press_detector #(
    parameter int TIME_BITS = bclp_pkg::TIME_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // sample stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [39:0]                       s_axis_tdata,  // raw_level, now_ms, pad
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [15:0]                       m_axis_tdata,  // event_res, clicks, pressed, pad
    // configuration writes
    input  logic                              i_cfg_we,
    input  logic [bclp_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [bclp_pkg::CFG_BITS-1:0]     i_cfg_wdata
);

    // Configuration registers
    bclp_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_low <= bclp_pkg::RST_ACTIVE_LOW;
            r_cfg.hold_time  <= bclp_pkg::RST_HOLD_TIME;
            r_cfg.click_gap  <= bclp_pkg::RST_CLICK_GAP;
            r_cfg.debounce   <= bclp_pkg::RST_DEBOUNCE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bclp_pkg::CFG_ACTIVE_LOW: r_cfg.active_low <= i_cfg_wdata[0];
                bclp_pkg::CFG_HOLD_TIME:  r_cfg.hold_time  <= i_cfg_wdata;
                bclp_pkg::CFG_CLICK_GAP:  r_cfg.click_gap  <= i_cfg_wdata;
                bclp_pkg::CFG_DEBOUNCE:   r_cfg.debounce   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register
    logic                           r_in_valid;
    logic                           r_in_raw;
    logic [bclp_pkg::NOW_BITS-1:0]  r_in_now;
    logic                           r_out_valid;
    logic                           w_advance;
    logic                           w_step;
    logic [TIME_BITS-1:0]           w_now;

    // Advance the input stage when the result register is free or draining
    assign w_advance     = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_step        = r_in_valid && w_advance;
    assign w_now         = TIME_BITS'(r_in_now);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_raw <= s_axis_tdata[0];
            r_in_now <= s_axis_tdata[bclp_pkg::NOW_BITS:1];
        end
    end

    // Debounce and phase machine, updated once per sample
    logic                            w_stable_next;
    logic                            w_stable;
    bclp_pkg::t_event                w_event;
    logic [bclp_pkg::CLICK_BITS-1:0] w_clicks;

    bclp_debounce #(
        .TIME_BITS (TIME_BITS)
    ) u_debounce (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_step),
        .i_raw_level   (r_in_raw),
        .i_now         (w_now),
        .i_cfg         (r_cfg),
        .o_stable_next (w_stable_next),
        .o_stable      (w_stable)
    );

    bclp_phase_fsm #(
        .TIME_BITS (TIME_BITS)
    ) u_phase (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_step),
        .i_act    (w_stable_next),
        .i_now    (w_now),
        .i_cfg    (r_cfg),
        .o_event  (w_event),
        .o_clicks (w_clicks)
    );

    // Result register
    bclp_pkg::t_event                r_out_event;
    logic [bclp_pkg::CLICK_BITS-1:0] r_out_clicks;
    logic                            r_out_pressed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
        if (w_step) begin
            r_out_event   <= w_event;
            r_out_clicks  <= w_clicks;
            r_out_pressed <= w_stable_next;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_pressed, r_out_clicks, r_out_event};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // A click report always carries at least one click
    a_click_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_event == bclp_pkg::EV_CLICK) |-> (r_out_clicks != '0))
        else $error("click reported with zero count");

    // A long-press repeat only fires while the button is held
    a_repeat_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_event == bclp_pkg::EV_LREP) |-> r_out_pressed)
        else $error("repeat reported while released");

    // Back-pressure only when both stages are full and the sink stalls
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && r_out_valid && !m_axis_tready))
        else $error("input stalled with room in the pipeline");

    // The registered debounce level follows the value computed for the sample
    a_stable_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> (w_stable == r_out_pressed))
        else $error("debounce state differs from reported level");

endmodule
